@@ design/tlf_pkg.sv @@
// tlf_pkg: shared types, constants and codes of the text line folder.
// Used by tlf_cell, tlf_chain, tlf_ctrl and text_line_folder.
`default_nettype none

package tlf_pkg;

  localparam int unsigned MaxWidth = 31;
  localparam int unsigned BufDepth = MaxWidth + 1;
  localparam int unsigned IdxW     = $clog2(BufDepth);
  localparam int unsigned CntW     = $clog2(BufDepth + 1);
  localparam int unsigned CfgW     = 5;

  typedef logic [7:0]      byte_t;
  typedef logic [IdxW-1:0] idx_t;
  typedef logic [CntW-1:0] cnt_t;
  typedef logic [CfgW-1:0] cfg_t;

  localparam byte_t ChSpace   = 8'd32;
  localparam byte_t ChTab     = 8'd9;
  localparam byte_t ChNl      = 8'd10;
  localparam cfg_t  FoldReset = 5'd4;

  localparam logic OpText = 1'b0;
  localparam logic OpEnd  = 1'b1;

  typedef enum logic [2:0] {
    StIdle  = 3'b001,
    StDrain = 3'b010,
    StNl    = 3'b100
  } state_e;

  typedef struct packed {
    logic  shift;
    logic  load;
    idx_t  load_idx;
    byte_t load_data;
  } chain_ctl_t;

  typedef struct packed {
    logic  valid;
    byte_t data;
    logic  last;
  } emit_t;

  typedef struct packed {
    logic idle;
    cnt_t cnt;
  } sts_t;

endpackage

`default_nettype wire

@@ design/tlf_cell.sv @@
// tlf_cell: one byte cell of the segment chain; loads a byte or takes its
// right neighbor's byte on a shift. Depends on tlf_pkg.
`default_nettype none

module tlf_cell (
  input  wire logic          clk_i,
  input  wire logic          load_i,
  input  wire logic          shift_i,
  input  wire tlf_pkg::byte_t load_data_i,
  input  wire tlf_pkg::byte_t nbr_i,
  output tlf_pkg::byte_t      data_o
);

  tlf_pkg::byte_t data_q, data_d;

  always_comb begin
    data_d = data_q;
    if (load_i) begin
      data_d = load_data_i;
    end else if (shift_i) begin
      data_d = nbr_i;
    end
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign data_o = data_q;

endmodule

`default_nettype wire

@@ design/tlf_chain.sv @@
// tlf_chain: row of tlf_cell byte cells holding the held line segment;
// cell 0 is the head. Depends on tlf_pkg and tlf_cell.
`default_nettype none

module tlf_chain (
  input  wire logic                clk_i,
  input  wire tlf_pkg::chain_ctl_t ctl_i,
  output tlf_pkg::byte_t           head_o
);

  tlf_pkg::byte_t cell_data [tlf_pkg::BufDepth];

  for (genvar i = 0; i < tlf_pkg::BufDepth; i++) begin : g_cell
    tlf_pkg::byte_t nbr;
    logic           load;

    if (i == tlf_pkg::BufDepth - 1) begin : g_tail
      assign nbr = '0;
    end else begin : g_mid
      assign nbr = cell_data[i+1];
    end

    assign load = ctl_i.load && (ctl_i.load_idx == tlf_pkg::idx_t'(i));

    tlf_cell u_cell (
      .clk_i      (clk_i),
      .load_i     (load),
      .shift_i    (ctl_i.shift),
      .load_data_i(ctl_i.load_data),
      .nbr_i      (nbr),
      .data_o     (cell_data[i])
    );
  end

  assign head_o = cell_data[0];

endmodule

`default_nettype wire

@@ design/tlf_ctrl.sv @@
// tlf_ctrl: fold width register, segment count, blank mark and the drain
// sequencer that steers the cell chain. Depends on tlf_pkg.
`default_nettype none

module tlf_ctrl (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                in_valid_i,
  output logic                     in_ready_o,
  input  wire logic                in_op_i,
  input  wire tlf_pkg::byte_t      in_char_i,
  input  wire logic                cfg_we_i,
  input  wire tlf_pkg::cfg_t       cfg_wdata_i,
  input  wire logic                slot_free_i,
  input  wire tlf_pkg::byte_t      head_i,
  output tlf_pkg::emit_t           emit_o,
  output tlf_pkg::chain_ctl_t      chain_o,
  output tlf_pkg::sts_t            sts_o
);

  tlf_pkg::state_e state_q, state_d;
  tlf_pkg::cfg_t   fold_q;
  tlf_pkg::cnt_t   cnt_q, cnt_d;
  tlf_pkg::cnt_t   drain_q, drain_d;
  logic            bv_q, bv_d;
  tlf_pkg::idx_t   bi_q, bi_d;
  logic            nl_en_q, nl_en_d;
  logic            nl_shift_q, nl_shift_d;

  tlf_pkg::cnt_t   eff_w;
  tlf_pkg::cnt_t   cnt_inc;
  logic            is_blank;
  logic            bv_n;
  tlf_pkg::idx_t   bi_n;

  always_comb begin
    if (fold_q == '0) begin
      eff_w = tlf_pkg::cnt_t'(1);
    end else if (tlf_pkg::cnt_t'(fold_q) > tlf_pkg::cnt_t'(tlf_pkg::MaxWidth)) begin
      eff_w = tlf_pkg::cnt_t'(tlf_pkg::MaxWidth);
    end else begin
      eff_w = tlf_pkg::cnt_t'(fold_q);
    end
  end

  assign cnt_inc  = cnt_q + tlf_pkg::cnt_t'(1);
  assign is_blank = (in_char_i == tlf_pkg::ChSpace) || (in_char_i == tlf_pkg::ChTab);
  assign bv_n     = is_blank ? 1'b1 : bv_q;
  assign bi_n     = is_blank ? cnt_q[tlf_pkg::IdxW-1:0] : bi_q;

  always_comb begin
    state_d    = state_q;
    cnt_d      = cnt_q;
    drain_d    = drain_q;
    bv_d       = bv_q;
    bi_d       = bi_q;
    nl_en_d    = nl_en_q;
    nl_shift_d = nl_shift_q;

    chain_o.shift     = 1'b0;
    chain_o.load      = 1'b0;
    chain_o.load_idx  = cnt_q[tlf_pkg::IdxW-1:0];
    chain_o.load_data = in_char_i;

    emit_o.valid = 1'b0;
    emit_o.data  = head_i;
    emit_o.last  = 1'b0;

    in_ready_o = (state_q == tlf_pkg::StIdle);

    case (state_q)
      tlf_pkg::StIdle: begin
        if (in_valid_i) begin
          if (in_op_i == tlf_pkg::OpEnd) begin
            bv_d = 1'b0;
            bi_d = '0;
            if (cnt_q != '0) begin
              drain_d = cnt_q;
              nl_en_d = 1'b0;
              state_d = tlf_pkg::StDrain;
            end
          end else if (in_char_i == tlf_pkg::ChNl) begin
            bv_d       = 1'b0;
            bi_d       = '0;
            drain_d    = cnt_q;
            nl_en_d    = 1'b1;
            nl_shift_d = 1'b0;
            state_d    = (cnt_q == '0) ? tlf_pkg::StNl : tlf_pkg::StDrain;
          end else begin
            chain_o.load = 1'b1;
            cnt_d        = cnt_inc;
            if (cnt_inc > eff_w) begin
              // fold: drain up to the blank and turn it into the newline,
              // or drain all but the newest byte and insert one
              nl_en_d = 1'b1;
              bv_d    = 1'b0;
              bi_d    = '0;
              if (bv_n) begin
                drain_d    = tlf_pkg::cnt_t'(bi_n);
                nl_shift_d = 1'b1;
                state_d    = (bi_n == '0) ? tlf_pkg::StNl : tlf_pkg::StDrain;
              end else begin
                drain_d    = cnt_q;
                nl_shift_d = 1'b0;
                state_d    = (cnt_q == '0) ? tlf_pkg::StNl : tlf_pkg::StDrain;
              end
            end else begin
              bv_d = bv_n;
              bi_d = bi_n;
            end
          end
        end
      end
      tlf_pkg::StDrain: begin
        if (slot_free_i) begin
          emit_o.valid  = 1'b1;
          emit_o.last   = (drain_q == tlf_pkg::cnt_t'(1)) && !nl_en_q;
          chain_o.shift = 1'b1;
          cnt_d         = cnt_q - tlf_pkg::cnt_t'(1);
          drain_d       = drain_q - tlf_pkg::cnt_t'(1);
          if (drain_q == tlf_pkg::cnt_t'(1)) begin
            state_d = nl_en_q ? tlf_pkg::StNl : tlf_pkg::StIdle;
          end
        end
      end
      tlf_pkg::StNl: begin
        if (slot_free_i) begin
          emit_o.valid = 1'b1;
          emit_o.data  = tlf_pkg::ChNl;
          emit_o.last  = 1'b1;
          if (nl_shift_q) begin
            chain_o.shift = 1'b1;
            cnt_d         = cnt_q - tlf_pkg::cnt_t'(1);
          end
          state_d = tlf_pkg::StIdle;
        end
      end
      default: begin
        state_d = tlf_pkg::StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= tlf_pkg::StIdle;
      fold_q     <= tlf_pkg::FoldReset;
      cnt_q      <= '0;
      drain_q    <= '0;
      bv_q       <= 1'b0;
      bi_q       <= '0;
      nl_en_q    <= 1'b0;
      nl_shift_q <= 1'b0;
    end else begin
      state_q    <= state_d;
      cnt_q      <= cnt_d;
      drain_q    <= drain_d;
      bv_q       <= bv_d;
      bi_q       <= bi_d;
      nl_en_q    <= nl_en_d;
      nl_shift_q <= nl_shift_d;
      if (cfg_we_i) begin
        fold_q <= cfg_wdata_i;
      end
    end
  end

  assign sts_o.idle = (state_q == tlf_pkg::StIdle);
  assign sts_o.cnt  = cnt_q;

endmodule

`default_nettype wire

@@ design/text_line_folder.sv @@
// Text line folder: wraps a byte stream at the last space or tab so that no
// output line holds more than fold_width characters (0 acts as 1); a line
// without a blank is broken before the overflowing byte. The held segment
// sits in a 32-cell byte chain that shifts one byte a cycle toward the
// output while the output slot is free. A byte that does not fold is only
// held; a fold, an input newline or an end-of-text transfer sends N held
// bytes plus an optional newline at one transfer per cycle while the output
// slot is free, and the input is held off until that is done. tlast marks the
// final byte sent for an input transfer. Depends on tlf_pkg, tlf_ctrl, tlf_chain.
`default_nettype none

module text_line_folder (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          s_tvalid_i,
  output logic               s_tready_o,
  input  wire logic [7:0]    s_tdata_i,   // [7:0] char_in
  input  wire logic          s_tuser_i,   // [0] op
  output logic               m_tvalid_o,
  input  wire logic          m_tready_i,
  output logic [7:0]         m_tdata_o,   // [7:0] char_out
  output logic               m_tlast_o,
  input  wire logic          cfg_we_i,
  input  wire logic [4:0]    cfg_wdata_i
);

  tlf_pkg::emit_t      emit;
  tlf_pkg::chain_ctl_t chain_ctl;
  tlf_pkg::sts_t       sts;
  tlf_pkg::byte_t      head;
  logic                slot_free;

  logic                out_valid_q, out_valid_d;
  tlf_pkg::byte_t      out_data_q, out_data_d;
  logic                out_last_q, out_last_d;

  assign slot_free = !out_valid_q || m_tready_i;

  tlf_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_tvalid_i),
    .in_ready_o (s_tready_o),
    .in_op_i    (s_tuser_i),
    .in_char_i  (s_tdata_i),
    .cfg_we_i   (cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i),
    .slot_free_i(slot_free),
    .head_i     (head),
    .emit_o     (emit),
    .chain_o    (chain_ctl),
    .sts_o      (sts)
  );

  tlf_chain u_chain (
    .clk_i (clk_i),
    .ctl_i (chain_ctl),
    .head_o(head)
  );

  always_comb begin
    out_valid_d = out_valid_q;
    out_data_d  = out_data_q;
    out_last_d  = out_last_q;
    if (emit.valid) begin
      out_valid_d = 1'b1;
      out_data_d  = emit.data;
      out_last_d  = emit.last;
    end else if (m_tready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_data_q <= out_data_d;
    out_last_q <= out_last_d;
  end

  assign m_tvalid_o = out_valid_q;
  assign m_tdata_o  = out_data_q;
  assign m_tlast_o  = out_last_q;

`ifndef SYNTHESIS
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sts.cnt <= tlf_pkg::cnt_t'(tlf_pkg::BufDepth))
    else $error("segment count beyond buffer depth");

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_tvalid_o && !m_tready_i) |-> !emit.valid)
    else $error("byte emitted over a stalled output");

  a_last_ends_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (emit.valid && emit.last) |=> sts.idle)
    else $error("run ended but sequencer not idle");

  a_busy_blocks_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    emit.valid |-> !s_tready_o)
    else $error("input accepted while draining");
`endif

endmodule

`default_nettype wire

@@ tb/testbench.sv @@
// Self-checking testbench for text_line_folder: stream driver, result monitor
// and a line-fold predictor that checks every output byte and its tlast.
// Depends on tlf_pkg and the text_line_folder RTL.
`timescale 1ns / 1ps

module testbench;

  localparam int unsigned CycleLimit = 1000000;
  localparam int unsigned SettleCycles = 40;

  typedef struct packed {
    logic           op;
    tlf_pkg::byte_t ch;
  } text_item_t;

  typedef struct packed {
    tlf_pkg::byte_t ch;
    logic           last;
  } out_byte_t;

  logic       clk_i = 1'b0;
  logic       rst_ni = 1'b0;
  logic       s_tvalid_i = 1'b0;
  logic       s_tready_o;
  logic [7:0] s_tdata_i = '0;
  logic       s_tuser_i = tlf_pkg::OpText;
  logic       m_tvalid_o;
  logic       m_tready_i = 1'b0;
  logic [7:0] m_tdata_o;
  logic       m_tlast_o;
  logic       cfg_we_i = 1'b0;
  logic [4:0] cfg_wdata_i = '0;

  text_line_folder dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .s_tvalid_i (s_tvalid_i),
    .s_tready_o (s_tready_o),
    .s_tdata_i  (s_tdata_i),
    .s_tuser_i  (s_tuser_i),
    .m_tvalid_o (m_tvalid_o),
    .m_tready_i (m_tready_i),
    .m_tdata_o  (m_tdata_o),
    .m_tlast_o  (m_tlast_o),
    .cfg_we_i   (cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i)
  );

  always #2 clk_i = ~clk_i;

  // predictor state
  tlf_pkg::cfg_t  fold_w = tlf_pkg::FoldReset;
  tlf_pkg::byte_t held[tlf_pkg::BufDepth];
  int unsigned    held_cnt = 0;
  bit             blank_seen = 1'b0;
  int unsigned    blank_at = 0;

  text_item_t  pending_q[$];
  out_byte_t   folded_q[$];
  text_item_t  cur_item;

  bit          in_took = 1'b0;
  bit          calm = 1'b0;
  int unsigned send_gap = 0;
  int unsigned stall_left = 0;
  int unsigned park_cycles = 0;
  int unsigned cycles = 0;
  int unsigned errors = 0;
  int unsigned items_in = 0;
  int unsigned bytes_out = 0;
  int unsigned nl_out = 0;
  int unsigned widths_used = 1;

  function automatic void fold_predict(logic op, tlf_pkg::byte_t ch);
    int unsigned    w;
    int unsigned    rest;
    tlf_pkg::byte_t keep;
    tlf_pkg::byte_t run[$];
    out_byte_t      ob;
    int             i;
    w = (fold_w == 0) ? 1 : ((fold_w > tlf_pkg::MaxWidth) ? tlf_pkg::MaxWidth : fold_w);
    if (op == tlf_pkg::OpEnd) begin
      for (i = 0; i < held_cnt; i++) run.push_back(held[i]);
      held_cnt = 0;
      blank_seen = 1'b0;
      blank_at = 0;
    end else if (ch == tlf_pkg::ChNl) begin
      for (i = 0; i < held_cnt; i++) run.push_back(held[i]);
      run.push_back(tlf_pkg::ChNl);
      held_cnt = 0;
      blank_seen = 1'b0;
      blank_at = 0;
    end else begin
      if (held_cnt < tlf_pkg::BufDepth) begin
        held[held_cnt] = ch;
        held_cnt++;
      end
      if (ch == tlf_pkg::ChSpace || ch == tlf_pkg::ChTab) begin
        blank_seen = 1'b1;
        blank_at = held_cnt - 1;
      end
      if (held_cnt > w) begin
        if (blank_seen) begin
          rest = held_cnt - blank_at - 1;
          for (i = 0; i < blank_at; i++) run.push_back(held[i]);
          run.push_back(tlf_pkg::ChNl);
          for (i = 0; i < rest; i++) held[i] = held[blank_at + 1 + i];
          held_cnt = rest;
        end else begin
          keep = held[held_cnt - 1];
          for (i = 0; i < held_cnt - 1; i++) run.push_back(held[i]);
          run.push_back(tlf_pkg::ChNl);
          held[0] = keep;
          held_cnt = 1;
        end
        blank_seen = 1'b0;
        blank_at = 0;
      end
    end
    for (i = 0; i < run.size(); i++) begin
      ob.ch = run[i];
      ob.last = (i == run.size() - 1);
      folded_q.push_back(ob);
    end
  endfunction

  // sender
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (!s_tvalid_i || in_took) begin
        if (send_gap > 0) begin
          send_gap--;
          s_tvalid_i <= 1'b0;
        end else if (!calm && $urandom_range(0, 9) == 0) begin
          send_gap = $urandom_range(1, 19) - 1;
          s_tvalid_i <= 1'b0;
        end else if (pending_q.size() > 0) begin
          cur_item = pending_q.pop_front();
          s_tvalid_i <= 1'b1;
          s_tdata_i <= cur_item.ch;
          s_tuser_i <= cur_item.op;
        end else begin
          s_tvalid_i <= 1'b0;
        end
      end
      in_took = 1'b0;
    end
  end

  // receiver, with a long hold-off on request
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (park_cycles > 0) begin
        park_cycles--;
        m_tready_i <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        m_tready_i <= 1'b0;
      end else if (!calm && $urandom_range(0, 7) == 0) begin
        stall_left = $urandom_range(1, 19) - 1;
        m_tready_i <= 1'b0;
      end else begin
        m_tready_i <= 1'b1;
      end
    end
  end

  // monitor
  always @(posedge clk_i) begin
    out_byte_t got;
    out_byte_t want;
    if (rst_ni) begin
      if (s_tvalid_i && s_tready_o) begin
        in_took = 1'b1;
        items_in++;
        fold_predict(s_tuser_i, s_tdata_i);
      end
      if (m_tvalid_o && m_tready_i) begin
        got.ch = m_tdata_o;
        got.last = m_tlast_o;
        bytes_out++;
        if (got.ch == tlf_pkg::ChNl) nl_out++;
        if (folded_q.size() == 0) begin
          errors++;
          if (errors <= 10)
            $display("ERROR: unexpected transfer char 0x%02h last %b", got.ch, got.last);
        end else begin
          want = folded_q.pop_front();
          if (got.ch !== want.ch || got.last !== want.last) begin
            errors++;
            if (errors <= 10)
              $display("ERROR: char exp 0x%02h got 0x%02h, last exp %b got %b",
                       want.ch, got.ch, want.last, got.last);
          end
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("TIMEOUT after %0d cycles", cycles);
      $display("Some tests failed");
      $finish;
    end
  end

  function automatic text_item_t random_text(bit nl_ok);
    text_item_t  it;
    int unsigned r;
    r = $urandom_range(0, 99);
    it.op = tlf_pkg::OpText;
    if (r < 60) it.ch = 8'd97 + tlf_pkg::byte_t'($urandom_range(0, 25));
    else if (r < 74) it.ch = tlf_pkg::ChSpace;
    else if (r < 79) it.ch = tlf_pkg::ChTab;
    else if (r < 84) it.ch = nl_ok ? tlf_pkg::ChNl : tlf_pkg::ChSpace;
    else if (r < 90) it.ch = tlf_pkg::byte_t'($urandom_range(0, 255));
    else if (r < 94) begin
      it.op = nl_ok ? tlf_pkg::OpEnd : tlf_pkg::OpText;
      it.ch = tlf_pkg::byte_t'($urandom_range(0, 255));
    end else it.ch = 8'd48 + tlf_pkg::byte_t'($urandom_range(0, 9));
    return it;
  endfunction

  task automatic wait_idle();
    do @(posedge clk_i);
    while (pending_q.size() > 0 || s_tvalid_i || folded_q.size() > 0);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic set_width(tlf_pkg::cfg_t w);
    @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= w;
    fold_w = w;
    widths_used++;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic random_phase(tlf_pkg::cfg_t w, int unsigned n, bit nl_ok);
    int i;
    set_width(w);
    for (i = 0; i < n; i++) pending_q.push_back(random_text(nl_ok));
    wait_idle();
  endtask

  function automatic text_item_t txt(tlf_pkg::byte_t c);
    text_item_t it;
    it.op = tlf_pkg::OpText;
    it.ch = c;
    return it;
  endfunction

  function automatic text_item_t eot(tlf_pkg::byte_t c);
    text_item_t it;
    it.op = tlf_pkg::OpEnd;
    it.ch = c;
    return it;
  endfunction

  initial begin
    int    k;
    string line_txt;
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // directed, reset width of 4
    pending_q.push_back(eot(8'h00));  // nothing held
    line_txt = "ab cdxyzabc ";
    for (k = 0; k < line_txt.len(); k++) pending_q.push_back(txt(line_txt[k]));
    pending_q.push_back(txt(8'h00));
    pending_q.push_back(txt(8'hFF));
    pending_q.push_back(txt(tlf_pkg::ChTab));
    pending_q.push_back(txt("k"));
    pending_q.push_back(txt(tlf_pkg::ChNl));
    pending_q.push_back(txt(8'hFF));
    pending_q.push_back(txt(8'h7F));
    pending_q.push_back(eot(8'hFF));
    wait_idle();

    random_phase(5'd0, 40, 1'b1);

    // widest line with the receiver parked so the input stalls
    set_width(5'd31);
    park_cycles = 400;
    for (k = 0; k < 45; k++) pending_q.push_back(random_text(1'b0));
    pending_q.push_back(eot(8'h5A));
    wait_idle();

    random_phase(5'd1, 30, 1'b1);
    for (k = 0; k < 4; k++) random_phase(tlf_pkg::cfg_t'($urandom_range(2, 30)), 22, 1'b1);

    calm = 1'b1;
    random_phase(tlf_pkg::cfg_t'($urandom_range(0, 31)), 40, 1'b1);

    $display("Covered %0d input transfers, %0d output bytes with %0d newlines, %0d widths.",
             items_in, bytes_out, nl_out, widths_used);
    if (errors == 0 && folded_q.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("%0d mismatches, %0d bytes still expected", errors, folded_q.size());
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
